// ===== design/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types and constants for the Miller-Rabin primality tester: witness
// bases, controller commands and datapath status.
// ----------------------------------------------------------------------------
package mrp_pkg;

	localparam int unsigned NUM_WIT = 12;
	localparam int unsigned WIT_IDX_W = 4;
	localparam int unsigned WIT_BASE_W = 6;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MOD3,
		CMD_SHIFT_D,
		CMD_POW_INIT,
		CMD_MUL_ACC,
		CMD_MUL_B,
		CMD_WB_ACC,
		CMD_WB_B,
		CMD_SQ_INIT,
		CMD_MUL_SQ,
		CMD_WB_SQ,
		CMD_NEXT_WIT
	} cmd_t;

	typedef struct packed {
		logic n_lt2;
		logic n_is_2_3;
		logic n_even;
		logic mod3_done;
		logic mod3_zero;
		logic d_even;
		logic e_zero;
		logic e_lsb;
		logic wit_end;
		logic n_le_base;
		logic x_one;
		logic x_nm1;
		logic r_lt_s;
		logic mm_busy;
		logic mm_done;
	} stat_t;

	// first twelve primes: deterministic for every 64-bit value
	function automatic logic [WIT_BASE_W-1:0] wit_base(input logic [WIT_IDX_W-1:0] idx);
		logic [WIT_BASE_W-1:0] b;
		case (idx)
			4'd0:    b = 6'd2;
			4'd1:    b = 6'd3;
			4'd2:    b = 6'd5;
			4'd3:    b = 6'd7;
			4'd4:    b = 6'd11;
			4'd5:    b = 6'd13;
			4'd6:    b = 6'd17;
			4'd7:    b = 6'd19;
			4'd8:    b = 6'd23;
			4'd9:    b = 6'd29;
			4'd10:   b = 6'd31;
			4'd11:   b = 6'd37;
			default: b = 6'd37;
		endcase
		return b;
	endfunction

endpackage

// ===== design/mrp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mrp_mulmod
// Bit-serial modular multiplier: (x * y) mod m by shift-and-add modular
// doubling, one modular addition per cycle, a doubling and then an add of x per bit of y.
// ----------------------------------------------------------------------------
module mrp_mulmod #(
	parameter int unsigned WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	input  logic [WIDTH-1:0] m,
	output logic             busy,
	output logic             done,
	output logic [WIDTH-1:0] result
);
	localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] m_q;
	logic [CNT_W-1:0] cnt_q;
	logic             phase_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH-1:0] add_b;
	logic [WIDTH-1:0] add_res;
	logic [WIDTH:0]   sum;

	// (acc + add_b) mod m, both operands below m
	assign add_b = phase_q ? x_q : acc_q;
	always_comb begin
		sum = {1'b0, acc_q} + {1'b0, add_b};
		if (sum >= {1'b0, m_q}) begin
			sum = sum - {1'b0, m_q};
		end
		add_res = sum[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (busy_q) begin
			if (!phase_q) begin
				acc_q <= add_res;
			end else begin
				if (y_q[WIDTH-1]) begin
					acc_q <= add_res;
				end
				y_q <= {y_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = acc_q;
endmodule

// ===== design/mrp_datapath.sv =====
// ----------------------------------------------------------------------------
// mrp_datapath
// Candidate, exponent and witness registers, the folding mod-3 check and the
// shared modular multiplier, driven by controller commands.
// ----------------------------------------------------------------------------
module mrp_datapath #(
	parameter int unsigned WIDTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mrp_pkg::cmd_t cmd,
	input  logic [63:0]   candidate,
	output mrp_pkg::stat_t stat
);
	import mrp_pkg::*;

	localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0]     n_q;
	logic [WIDTH-1:0]     nm1_q;
	logic [WIDTH-1:0]     d_q;
	logic [WIDTH-1:0]     e_q;
	logic [WIDTH-1:0]     acc_q;
	logic [WIDTH-1:0]     b_q;
	logic [CNT_W-1:0]     s_q;
	logic [CNT_W-1:0]     r_q;
	logic [WIT_IDX_W-1:0] wit_q;
	logic [1:0]           m3_cnt_q;
	logic [7:0]           m3_q;
	logic                 m3_done_q;
	logic [63:0]          m3_in;
	logic [7:0]           m3_next;
	logic                 mm_start;
	logic [WIDTH-1:0]     mm_x;
	logic [WIDTH-1:0]     mm_y;
	logic                 mm_busy;
	logic                 mm_done;
	logic [WIDTH-1:0]     mm_res;
	logic [WIDTH-1:0]     base;

	// 16 is 1 mod 3, so the nibble sum keeps the remainder mod 3
	function automatic logic [7:0] nib_sum(input logic [63:0] v);
		logic [7:0] total;
		total = '0;
		for (int i = 0; i < 16; i++) begin
			total = total + 8'(v[4*i +: 4]);
		end
		return total;
	endfunction

	assign base = WIDTH'(wit_base(wit_q));

	always_comb begin
		mm_start = 1'b0;
		mm_x     = acc_q;
		mm_y     = b_q;
		case (cmd)
			CMD_MUL_ACC: begin
				mm_start = 1'b1;
			end
			CMD_MUL_B: begin
				mm_start = 1'b1;
				mm_x     = b_q;
			end
			CMD_MUL_SQ: begin
				mm_start = 1'b1;
				mm_y     = acc_q;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	mrp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.x      (mm_x),
		.y      (mm_y),
		.m      (n_q),
		.busy   (mm_busy),
		.done   (mm_done),
		.result (mm_res)
	);

	// three folds: candidate to at most 240, then 29, then 15
	always_comb begin
		m3_in   = (m3_cnt_q == 2'd0) ? 64'(n_q) : 64'(m3_q);
		m3_next = nib_sum(m3_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m3_cnt_q  <= '0;
			m3_q      <= '0;
			m3_done_q <= 1'b0;
			s_q       <= '0;
			r_q       <= '0;
			wit_q     <= '0;
		end else begin
			case (cmd)
				CMD_LOAD: begin
					m3_cnt_q  <= '0;
					m3_q      <= '0;
					m3_done_q <= 1'b0;
					s_q       <= '0;
					wit_q     <= '0;
				end
				CMD_MOD3: begin
					m3_q <= m3_next;
					if (m3_cnt_q == 2'd2) begin
						m3_done_q <= 1'b1;
					end else begin
						m3_cnt_q <= m3_cnt_q + 2'd1;
					end
				end
				CMD_SHIFT_D:  s_q   <= s_q + 1'b1;
				CMD_SQ_INIT:  r_q   <= CNT_W'(1);
				CMD_WB_SQ:    r_q   <= r_q + 1'b1;
				CMD_NEXT_WIT: wit_q <= wit_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				n_q   <= candidate[WIDTH-1:0];
				nm1_q <= candidate[WIDTH-1:0] - 1'b1;
				d_q   <= candidate[WIDTH-1:0] - 1'b1;
			end
			CMD_SHIFT_D: d_q <= d_q >> 1;
			CMD_POW_INIT: begin
				acc_q <= WIDTH'(1);
				b_q   <= base;
				e_q   <= d_q;
			end
			CMD_WB_ACC: acc_q <= mm_res;
			CMD_WB_B: begin
				b_q <= mm_res;
				e_q <= e_q >> 1;
			end
			CMD_WB_SQ: acc_q <= mm_res;
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.n_lt2     = n_q < WIDTH'(2);
		stat.n_is_2_3  = (n_q == WIDTH'(2)) || (n_q == WIDTH'(3));
		stat.n_even    = ~n_q[0];
		stat.mod3_done = m3_done_q;
		stat.mod3_zero = m3_q inside {8'd0, 8'd3, 8'd6, 8'd9, 8'd12, 8'd15};
		stat.d_even    = ~d_q[0];
		stat.e_zero    = e_q == '0;
		stat.e_lsb     = e_q[0];
		stat.wit_end   = wit_q == WIT_IDX_W'(NUM_WIT);
		stat.n_le_base = n_q <= base;
		stat.x_one     = acc_q == WIDTH'(1);
		stat.x_nm1     = acc_q == nm1_q;
		stat.r_lt_s    = r_q < s_q;
		stat.mm_busy   = mm_busy;
		stat.mm_done   = mm_done;
	end
endmodule

// ===== design/mrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrp_ctrl
// Controller: screens small candidates, walks the witness bases through the
// square-and-multiply and squaring loops and hands out the verdict.
// ----------------------------------------------------------------------------
module mrp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           is_prime,
	input  mrp_pkg::stat_t stat,
	output mrp_pkg::cmd_t  cmd
);
	import mrp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_MOD3,
		ST_SPLIT,
		ST_WIT,
		ST_POW,
		ST_WAIT_ACC,
		ST_POW_B,
		ST_WAIT_B,
		ST_CHECK,
		ST_SQ,
		ST_WAIT_SQ,
		ST_SQ_CHK,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   res_q;
	logic   out_valid_q;
	logic   is_prime_q;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	always_comb begin
		cmd = CMD_NONE;
		case (state_q)
			ST_IDLE:     if (in_valid) cmd = CMD_LOAD;
			ST_MOD3:     if (!stat.mod3_done) cmd = CMD_MOD3;
			ST_SPLIT:    if (stat.d_even) cmd = CMD_SHIFT_D;
			ST_WIT:      if (!stat.wit_end && !stat.n_le_base) cmd = CMD_POW_INIT;
			ST_POW: begin
				if (!stat.e_zero) begin
					cmd = stat.e_lsb ? CMD_MUL_ACC : CMD_MUL_B;
				end
			end
			ST_WAIT_ACC: if (stat.mm_done) cmd = CMD_WB_ACC;
			ST_POW_B:    cmd = CMD_MUL_B;
			ST_WAIT_B:   if (stat.mm_done) cmd = CMD_WB_B;
			ST_CHECK:    cmd = (stat.x_one || stat.x_nm1) ? CMD_NEXT_WIT : CMD_SQ_INIT;
			ST_SQ:       if (stat.r_lt_s) cmd = CMD_MUL_SQ;
			ST_WAIT_SQ:  if (stat.mm_done) cmd = CMD_WB_SQ;
			ST_SQ_CHK:   if (stat.x_nm1) cmd = CMD_NEXT_WIT;
			default:     cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			is_prime_q  <= 1'b0;
		end else begin
			// in the hold state the output register is handled below
			if (out_valid_q && out_ready && state_q != ST_HOLD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_CLASSIFY;
				ST_CLASSIFY: begin
					if (stat.n_lt2) begin
						res_q   <= 1'b0;
						state_q <= ST_HOLD;
					end else if (stat.n_is_2_3) begin
						res_q   <= 1'b1;
						state_q <= ST_HOLD;
					end else if (stat.n_even) begin
						res_q   <= 1'b0;
						state_q <= ST_HOLD;
					end else begin
						state_q <= ST_MOD3;
					end
				end
				ST_MOD3: begin
					if (stat.mod3_done) begin
						if (stat.mod3_zero) begin
							res_q   <= 1'b0;
							state_q <= ST_HOLD;
						end else begin
							state_q <= ST_SPLIT;
						end
					end
				end
				ST_SPLIT: if (!stat.d_even) state_q <= ST_WIT;
				ST_WIT: begin
					if (stat.wit_end || stat.n_le_base) begin
						res_q   <= 1'b1;
						state_q <= ST_HOLD;
					end else begin
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (stat.e_zero) begin
						state_q <= ST_CHECK;
					end else if (stat.e_lsb) begin
						state_q <= ST_WAIT_ACC;
					end else begin
						state_q <= ST_WAIT_B;
					end
				end
				ST_WAIT_ACC: if (stat.mm_done) state_q <= ST_POW_B;
				ST_POW_B:    state_q <= ST_WAIT_B;
				ST_WAIT_B:   if (stat.mm_done) state_q <= ST_POW;
				ST_CHECK:    state_q <= (stat.x_one || stat.x_nm1) ? ST_WIT : ST_SQ;
				ST_SQ: begin
					if (stat.r_lt_s) begin
						state_q <= ST_WAIT_SQ;
					end else begin
						res_q   <= 1'b0;
						state_q <= ST_HOLD;
					end
				end
				ST_WAIT_SQ: if (stat.mm_done) state_q <= ST_SQ_CHK;
				ST_SQ_CHK:  state_q <= stat.x_nm1 ? ST_WIT : ST_SQ;
				ST_HOLD: begin
					// wait for the previous verdict to be taken
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						is_prime_q  <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/miller_rabin_prime_test_64.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64
// Deterministic Miller-Rabin primality test of one WIDTH-bit candidate with
// witness bases 2 to 37; one verdict per candidate.
// ----------------------------------------------------------------------------
// One candidate is tested at a time; the next is taken once the verdict is
// in the output register. Candidate bits at and above WIDTH are ignored.
// Small values and evens are settled in the classify state, multiples of 3
// after the mod-3 folds, and the verdict goes out once the output register is free.
// Otherwise the time is set by the shared bit-serial modular multiplier:
// each witness needs at most about 2 * WIDTH multiplications in all for
// a^d mod n and the s - 1 squarings, which the multiplier runs one at a time.
module miller_rabin_prime_test_64 #(
	parameter int unsigned WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] candidate,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_prime
);
	import mrp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_prime  (is_prime),
		.stat      (stat),
		.cmd       (cmd)
	);

	mrp_datapath #(.WIDTH(WIDTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.candidate (candidate),
		.stat      (stat)
	);

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("block took a candidate while busy");

	a_load_only_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_LOAD) |-> (in_valid && in_ready))
		else $error("candidate loaded without a transfer");

	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_MUL_ACC || cmd == CMD_MUL_B || cmd == CMD_MUL_SQ) |-> !stat.mm_busy)
		else $error("multiplier started while busy");
`endif
endmodule

// ===== tb/miller_rabin_prime_test_64_tb.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_tb
// Candidates go in over a valid/ready channel and verdicts come back the same
// way. Each verdict is checked against a primality predictor that uses
// 128-bit modular products. The run goes through four phases of idling and
// stalling on the two sides.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 100_000_000;
	localparam int unsigned DRAIN_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] candidate;
	logic        out_valid;
	logic        out_ready;
	logic        is_prime;

	logic [63:0] pending_candidates[$];
	bit          expected_verdicts[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned error_count;
	int unsigned cycle_count;
	logic        in_xfer;

	miller_rabin_prime_test_64 #(.WIDTH(64)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.candidate (candidate),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_prime  (is_prime)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [127:0] prod;
		prod = {64'd0, x} * {64'd0, y};
		return 64'(prod % {64'd0, m});
	endfunction

	function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1;
		b = b % m;
		while (e != 64'd0) begin
			if (e[0])
				acc = mul_mod(acc, b, m);
			b = mul_mod(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic bit prime_verdict(logic [63:0] n);
		logic [63:0] bases[12];
		logic [63:0] d;
		logic [63:0] x;
		int unsigned s;
		bit          passed;
		bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19,
			64'd23, 64'd29, 64'd31, 64'd37};
		if (n < 64'd2)
			return 1'b0;
		if (n == 64'd2 || n == 64'd3)
			return 1'b1;
		if (n[0] == 1'b0 || (n % 64'd3) == 64'd0)
			return 1'b0;
		d = n - 64'd1;
		s = 0;
		while (d[0] == 1'b0) begin
			d = d >> 1;
			s++;
		end
		foreach (bases[i]) begin
			if (n <= bases[i])
				break;
			x = pow_mod(bases[i], d, n);
			if (x == 64'd1 || x == n - 64'd1)
				continue;
			passed = 1'b0;
			for (int unsigned r = 1; r < s; r++) begin
				x = mul_mod(x, x, n);
				if (x == n - 64'd1) begin
					passed = 1'b1;
					break;
				end
			end
			if (!passed)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			candidate <= 64'd0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
			if (in_valid && !in_xfer) begin
				// hold until the transfer happens
			end else if (pending_candidates.size() != 0 &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				in_valid  <= 1'b1;
				candidate <= pending_candidates.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: transfers are sampled on the rising edge
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[miller_rabin_prime_test_64] ERROR");
			$finish;
		end
		in_xfer <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_verdicts.push_back(prime_verdict(candidate));
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict %0b with nothing expected", is_prime));
			end else begin
				if (is_prime !== expected_verdicts[0])
					report_mismatch($sformatf("is_prime %0b, expected %0b",
						is_prime, expected_verdicts[0]));
				void'(expected_verdicts.pop_front());
			end
		end
	end

	task automatic push_random(int unsigned count);
		logic [63:0] v;
		for (int unsigned i = 0; i < count; i++) begin
			case ($urandom_range(9, 0))
				0, 1, 2: v = 64'($urandom_range(300, 0));
				3, 4:    v = 64'($urandom());
				9: begin
					// full-width prime, the slowest case
					v = rand64() | 64'd1;
					while (!prime_verdict(v))
						v = v + 64'd2;
				end
				default: v = rand64();
			endcase
			pending_candidates.push_back(v);
		end
	endtask

	task automatic wait_idle();
		while (pending_candidates.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		candidate      = 64'd0;
		out_ready      = 1'b0;
		in_xfer        = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count    = 0;
		cycle_count    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// edge values, small values and known strong pseudoprimes
		pending_candidates = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9,
			64'd25, 64'd37, 64'd41, 64'd561, 64'd2047, 64'd1373653,
			64'd3215031751, 64'd4294967291, 64'h8000_0000_0000_0000,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
			64'hFFFF_FFFF_FFFF_FFC5, 64'h1FFF_FFFF_FFFF_FFFF,
			64'd3825123056546413051};
		push_random(10);
		wait_idle();

		send_idle_pct  = 81;
		recv_stall_pct = 0;
		push_random(23);
		wait_idle();

		send_idle_pct  = 0;
		recv_stall_pct = 81;
		push_random(23);
		wait_idle();

		send_idle_pct  = 26;
		recv_stall_pct = 26;
		push_random(23);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[miller_rabin_prime_test_64] OK");
		else
			$display("[miller_rabin_prime_test_64] ERROR");
		$finish;
	end

endmodule
